/* src/mrcc_pkg.sv */
// Shared types and constants for the mesh route candidate compute block.
`timescale 1ns / 1ps

package mrcc_pkg;

    localparam int COORD_W = 4;
    localparam int MODE_W  = 3;
    localparam int DIR_W   = 4;
    localparam int COUNT_W = 2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DIR_W-1:0]   dir_mask_t;

    // Routing schemes selected by the mode register
    typedef enum logic [MODE_W-1:0] {
        MODE_XY             = 3'd0,
        MODE_WEST_FIRST     = 3'd1,
        MODE_NORTH_LAST     = 3'd2,
        MODE_NEGATIVE_FIRST = 3'd3,
        MODE_ODD_EVEN       = 3'd4,
        MODE_FULLY_ADAPTIVE = 3'd5
    } route_mode_t;

    // Direction bits of the candidate mask
    localparam dir_mask_t DIR_NORTH = 4'b0001;
    localparam dir_mask_t DIR_EAST  = 4'b0010;
    localparam dir_mask_t DIR_SOUTH = 4'b0100;
    localparam dir_mask_t DIR_WEST  = 4'b1000;

    // Header coordinates of one head flit
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t src_x;
        coord_t dst_x;
        coord_t dst_y;
    } route_req_t;

    // Routing answer for one head flit
    typedef struct packed {
        logic                 deliver_local;
        dir_mask_t            direction_mask;
        logic [COUNT_W-1:0]   candidate_count;
    } route_rsp_t;

endpackage

/* src/mrcc_route_logic.sv */
// Combinational route candidate computation for all supported routing schemes.
`timescale 1ns / 1ps

module mrcc_route_logic (
    input  logic [mrcc_pkg::MODE_W-1:0] mode,
    input  mrcc_pkg::route_req_t        req,
    output mrcc_pkg::route_rsp_t        rsp
);
    import mrcc_pkg::*;

    logic      east_of;
    logic      west_of;
    logic      north_of;
    logic      south_of;
    logic      same_col;
    logic      same_row;
    dir_mask_t xy_mask;
    dir_mask_t oe_mask;
    dir_mask_t mask;
    logic [COORD_W:0] cur_x_plus_one;

    // Compare destination against the current node
    assign east_of  = req.dst_x > req.cur_x;
    assign west_of  = req.dst_x < req.cur_x;
    assign south_of = req.dst_y > req.cur_y;
    assign north_of = req.dst_y < req.cur_y;
    assign same_col = req.dst_x == req.cur_x;
    assign same_row = req.dst_y == req.cur_y;
    assign cur_x_plus_one = {1'b0, req.cur_x} + {{COORD_W{1'b0}}, 1'b1};

    // Dimension-order step: X first, then Y
    always_comb
    begin
        if (east_of)
            xy_mask = DIR_EAST;
        else if (west_of)
            xy_mask = DIR_WEST;
        else if (south_of)
            xy_mask = DIR_SOUTH;
        else
            xy_mask = DIR_NORTH;
    end

    // Odd-even turn model: restrict turns by column parity
    always_comb
    begin
        oe_mask = '0;
        if (same_col)
        begin
            oe_mask = north_of ? DIR_NORTH : DIR_SOUTH;
        end
        else if (east_of)
        begin
            if (same_row)
            begin
                oe_mask = DIR_EAST;
            end
            else
            begin
                if (req.cur_x[0] || (req.cur_x == req.src_x))
                    oe_mask = oe_mask | (north_of ? DIR_NORTH : DIR_SOUTH);
                if (req.dst_x[0] || ({1'b0, req.dst_x} != cur_x_plus_one))
                    oe_mask = oe_mask | DIR_EAST;
            end
        end
        else
        begin
            oe_mask = DIR_WEST;
            if (!req.cur_x[0])
            begin
                if (north_of)
                    oe_mask = oe_mask | DIR_NORTH;
                if (south_of)
                    oe_mask = oe_mask | DIR_SOUTH;
            end
        end
    end

    // Select the scheme's candidate set
    always_comb
    begin
        unique case (mode)
            MODE_WEST_FIRST:
            begin
                if (!east_of || same_row)
                    mask = xy_mask;
                else
                    mask = (north_of ? DIR_NORTH : DIR_SOUTH) | DIR_EAST;
            end
            MODE_NORTH_LAST:
            begin
                if (same_col || !south_of)
                    mask = xy_mask;
                else
                    mask = DIR_SOUTH | (west_of ? DIR_WEST : DIR_EAST);
            end
            MODE_NEGATIVE_FIRST:
            begin
                if (east_of && north_of)
                    mask = DIR_NORTH | DIR_EAST;
                else if (west_of && south_of)
                    mask = DIR_SOUTH | DIR_WEST;
                else if (east_of && south_of)
                    mask = DIR_SOUTH;
                else
                    mask = xy_mask;
            end
            MODE_ODD_EVEN:
            begin
                mask = oe_mask;
            end
            MODE_FULLY_ADAPTIVE:
            begin
                if (same_col || same_row)
                    mask = xy_mask;
                else
                    mask = (north_of ? DIR_NORTH : DIR_SOUTH)
                         | (east_of ? DIR_EAST : DIR_WEST);
            end
            default:
            begin
                mask = xy_mask;
            end
        endcase
    end

    // Local delivery overrides any direction
    always_comb
    begin
        rsp.deliver_local   = same_col && same_row;
        rsp.direction_mask  = rsp.deliver_local ? '0 : mask;
        rsp.candidate_count = COUNT_W'($countones(rsp.direction_mask));
    end

endmodule

/* src/mesh_route_candidate_compute_unit.sv */
// Top level of the mesh route candidate compute block: input and result registers.
// The input register captures each header; the result register then captures its answer and drives the
// output port. Throughput: one head flit per cycle while out_stall is low; the routing logic sits
// between the input register and the result register and is a single pass of comparisons.
// in_stall rises only while both registers are full and the output is stalled.
// Reset (rst_n low, asynchronous) empties both registers and sets the mode to XY.
`timescale 1ns / 1ps

module mesh_route_candidate_compute_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mrcc_pkg::MODE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  mrcc_pkg::coord_t              cur_x,
    input  mrcc_pkg::coord_t              cur_y,
    input  mrcc_pkg::coord_t              src_x,
    input  mrcc_pkg::coord_t              dst_x,
    input  mrcc_pkg::coord_t              dst_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          deliver_local,
    output mrcc_pkg::dir_mask_t           direction_mask,
    output logic [mrcc_pkg::COUNT_W-1:0]  candidate_count
);
    import mrcc_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic              req_valid_reg;
    route_req_t        req_reg;
    logic              rsp_valid_reg;
    route_rsp_t        rsp_reg;
    route_rsp_t        rsp_next;
    logic              rsp_load;
    logic              req_load;

    // Mode register: always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_XY;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // Pipeline flow control
    assign rsp_load = !rsp_valid_reg || !out_stall;
    assign in_stall = req_valid_reg && !rsp_load;
    assign req_load = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (!in_stall)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            req_reg.cur_x <= cur_x;
            req_reg.cur_y <= cur_y;
            req_reg.src_x <= src_x;
            req_reg.dst_x <= dst_x;
            req_reg.dst_y <= dst_y;
        end
    end

    mrcc_route_logic u_route_logic (
        .mode (mode_reg),
        .req  (req_reg),
        .rsp  (rsp_next)
    );

    // Result register: hold while stalled, advance otherwise
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load && req_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign out_valid       = rsp_valid_reg;
    assign deliver_local   = rsp_reg.deliver_local;
    assign direction_mask  = rsp_reg.direction_mask;
    assign candidate_count = rsp_reg.candidate_count;

endmodule

/* src/mrcc_checker.sv */
// Port-level assertions for the mesh route candidate compute block, with bind.
`timescale 1ns / 1ps

module mrcc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          deliver_local,
    input  mrcc_pkg::dir_mask_t           direction_mask,
    input  logic [mrcc_pkg::COUNT_W-1:0]  candidate_count
);
    import mrcc_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its mask
    a_mask_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(direction_mask))
        else $error("direction mask changed while stalled");

    // Count matches the mask
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(candidate_count) == $countones(direction_mask)))
        else $error("candidate count disagrees with mask");

    // Local delivery carries no direction
    a_local: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deliver_local |-> (direction_mask == '0))
        else $error("local delivery with a direction set");

    // Input back-pressure only when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

endmodule

bind mesh_route_candidate_compute_unit mrcc_checker u_mrcc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .deliver_local   (deliver_local),
    .direction_mask  (direction_mask),
    .candidate_count (candidate_count)
);

/* tb/tb_top.sv */
// Self-checking testbench for the mesh route candidate compute unit.
`timescale 1ns / 1ps

module tb_top;

    import mrcc_pkg::*;

    // Mode register values with no scheme of their own; they route as XY
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int MAX_IDLE        = 18;
    localparam int RX_HOLD_CYCLES  = 150;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int PHASES          = 8;
    // Longest quiet stretch of a correct run: the receiver hold-off plus a
    // sender gap, a receiver stall and the pipeline.
    localparam int WATCHDOG_LIMIT  = 2000;

    // One directed row: mode to run under, header, and a hand-written answer used only when typed is set
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        route_req_t        req;
        bit                typed;
        route_rsp_t        rsp;
    } route_case_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    coord_t               cur_x;
    coord_t               cur_y;
    coord_t               src_x;
    coord_t               dst_x;
    coord_t               dst_y;
    logic                 out_valid;
    logic                 out_stall;
    logic                 deliver_local;
    dir_mask_t            direction_mask;
    logic [COUNT_W-1:0]   candidate_count;

    route_rsp_t           route_expect_q[$];
    route_case_t          route_cases[$];
    logic [MODE_W-1:0]    routing_mode_q;
    int                   route_errors = 0;
    int                   quiet_cycles = 0;
    bit                   no_idle = 1'b0;
    bit                   rx_hold_req = 1'b0;

    mesh_route_candidate_compute_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cur_x           (cur_x),
        .cur_y           (cur_y),
        .src_x           (src_x),
        .dst_x           (dst_x),
        .dst_y           (dst_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .deliver_local   (deliver_local),
        .direction_mask  (direction_mask),
        .candidate_count (candidate_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Dimension-order step: X first, then Y
    function automatic dir_mask_t xy_step(input route_req_t r);
        if (r.dst_x > r.cur_x)
            return DIR_EAST;
        if (r.dst_x < r.cur_x)
            return DIR_WEST;
        if (r.dst_y > r.cur_y)
            return DIR_SOUTH;
        return DIR_NORTH;
    endfunction

    // Admissible output set for one head flit under the given mode
    function automatic route_rsp_t route_candidates(input logic [MODE_W-1:0] mode,
                                                    input route_req_t r);
        route_rsp_t rsp;
        dir_mask_t  m;
        logic       north;
        logic       south;
        logic       east;
        logic       west;
        rsp   = '0;
        north = r.dst_y < r.cur_y;
        south = r.dst_y > r.cur_y;
        east  = r.dst_x > r.cur_x;
        west  = r.dst_x < r.cur_x;
        if (!(north || south || east || west))
        begin
            rsp.deliver_local = 1'b1;
            return rsp;
        end
        m = xy_step(r);
        case (mode)
            MODE_WEST_FIRST:
                if (east && (north || south))
                    m = (north ? DIR_NORTH : DIR_SOUTH) | DIR_EAST;
            MODE_NORTH_LAST:
                if (south && (east || west))
                    m = DIR_SOUTH | (east ? DIR_EAST : DIR_WEST);
            MODE_NEGATIVE_FIRST:
                if (east && north)
                    m = DIR_NORTH | DIR_EAST;
                else if (west && south)
                    m = DIR_SOUTH | DIR_WEST;
                else if (east && south)
                    m = DIR_SOUTH;
            MODE_ODD_EVEN:
                if (east && (north || south))
                begin
                    // vertical turns only in odd columns or the source column
                    m = '0;
                    if (r.cur_x[0] || r.cur_x == r.src_x)
                        m = m | (north ? DIR_NORTH : DIR_SOUTH);
                    // keep east open unless it would end one short of an even column
                    if (r.dst_x[0] || (r.dst_x - r.cur_x) != 4'd1)
                        m = m | DIR_EAST;
                end
                else if (west)
                begin
                    m = DIR_WEST;
                    if (!r.cur_x[0] && north)
                        m = m | DIR_NORTH;
                    if (!r.cur_x[0] && south)
                        m = m | DIR_SOUTH;
                end
            MODE_FULLY_ADAPTIVE:
                if ((east || west) && (north || south))
                    m = (north ? DIR_NORTH : DIR_SOUTH) | (east ? DIR_EAST : DIR_WEST);
            default:
                ;
        endcase
        rsp.direction_mask  = m;
        rsp.candidate_count = COUNT_W'($countones(m));
        return rsp;
    endfunction

    function automatic route_case_t route_case(input logic [MODE_W-1:0] mode,
                                               input coord_t cx, input coord_t cy,
                                               input coord_t sx, input coord_t dx,
                                               input coord_t dy, input bit typed,
                                               input logic local_hit, input dir_mask_t m,
                                               input logic [COUNT_W-1:0] n);
        route_case_t c;
        c.mode                = mode;
        c.req.cur_x           = cx;
        c.req.cur_y           = cy;
        c.req.src_x           = sx;
        c.req.dst_x           = dx;
        c.req.dst_y           = dy;
        c.typed               = typed;
        c.rsp.deliver_local   = local_hit;
        c.rsp.direction_mask  = m;
        c.rsp.candidate_count = n;
        return c;
    endfunction

    // Drop valid and hold until every expected route has come back
    task automatic drain_routes();
        in_valid <= 1'b0;
        while (route_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_routing_mode(input logic [MODE_W-1:0] mode);
        drain_routes();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        routing_mode_q = mode;
    endtask

    // Offer one header after a random gap and record its answer on transfer
    task automatic send_route(input route_req_t req, input route_rsp_t rsp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cur_x    <= req.cur_x;
        cur_y    <= req.cur_y;
        src_x    <= req.src_x;
        dst_x    <= req.dst_x;
        dst_y    <= req.dst_y;
        do
            @(posedge clk);
        while (in_stall);
        route_expect_q = {route_expect_q, rsp};
    endtask

    // Compare each result transfer with the oldest expected route
    always @(posedge clk)
    begin : result_check
        route_rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (route_expect_q.size() == 0)
            begin
                $error("unexpected result: deliver_local %0b direction_mask %0h count %0d",
                       deliver_local, direction_mask, candidate_count);
                route_errors++;
            end
            else
            begin
                want = route_expect_q.pop_front();
                if (deliver_local !== want.deliver_local)
                begin
                    $error("deliver_local: expected %0b, got %0b",
                           want.deliver_local, deliver_local);
                    route_errors++;
                end
                if (direction_mask !== want.direction_mask)
                begin
                    $error("direction_mask: expected %0h, got %0h",
                           want.direction_mask, direction_mask);
                    route_errors++;
                end
                if (candidate_count !== want.candidate_count)
                begin
                    $error("candidate_count: expected %0d, got %0d",
                           want.candidate_count, candidate_count);
                    route_errors++;
                end
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer, or RX_HOLD_CYCLES after rx_hold_req
    initial
    begin : result_sink
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold        = RX_HOLD_CYCLES;
            end
            else
                hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        route_req_t        req;
        int                kind;
        logic [MODE_W-1:0] phase_modes [PHASES];

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= MODE_XY;
        in_valid       <= 1'b0;
        cur_x          <= '0;
        cur_y          <= '0;
        src_x          <= '0;
        dst_x          <= '0;
        dst_y          <= '0;
        routing_mode_q = MODE_XY;

        phase_modes = '{MODE_ODD_EVEN, MODE_XY, MODE_FULLY_ADAPTIVE, MODE_WEST_FIRST,
                        MODE_NORTH_LAST, MODE_NEGATIVE_FIRST, MODE_SPARE_6, MODE_SPARE_7};

        // Directed rows; the first ones run under the mode left by reset
        route_cases = {route_cases, route_case(MODE_XY, 0, 0, 0, 0, 0, 1, 1, '0, 0)};
        route_cases = {route_cases, route_case(MODE_XY, 15, 15, 15, 15, 15, 1, 1, '0, 0)};
        route_cases = {route_cases, route_case(MODE_XY, 0, 0, 0, 15, 15, 1, 0, DIR_EAST, 1)};
        route_cases = {route_cases, route_case(MODE_XY, 15, 15, 0, 0, 0, 1, 0, DIR_WEST, 1)};
        route_cases = {route_cases, route_case(MODE_XY, 7, 0, 0, 7, 15, 1, 0, DIR_SOUTH, 1)};
        route_cases = {route_cases, route_case(MODE_XY, 7, 15, 0, 7, 0, 1, 0, DIR_NORTH, 1)};
        route_cases = {route_cases, route_case(MODE_WEST_FIRST, 0, 15, 0, 15, 0, 1, 0,
                                               DIR_NORTH | DIR_EAST, 2)};
        route_cases = {route_cases, route_case(MODE_WEST_FIRST, 15, 0, 15, 0, 15, 1, 0,
                                               DIR_WEST, 1)};
        route_cases = {route_cases, route_case(MODE_NORTH_LAST, 15, 0, 0, 0, 15, 1, 0,
                                               DIR_SOUTH | DIR_WEST, 2)};
        route_cases = {route_cases, route_case(MODE_NORTH_LAST, 0, 15, 0, 15, 0, 1, 0,
                                               DIR_EAST, 1)};
        route_cases = {route_cases, route_case(MODE_NEGATIVE_FIRST, 0, 15, 0, 15, 0, 1, 0,
                                               DIR_NORTH | DIR_EAST, 2)};
        route_cases = {route_cases, route_case(MODE_NEGATIVE_FIRST, 15, 0, 0, 0, 15, 1, 0,
                                               DIR_SOUTH | DIR_WEST, 2)};
        route_cases = {route_cases, route_case(MODE_NEGATIVE_FIRST, 0, 0, 0, 15, 15, 1, 0,
                                               DIR_SOUTH, 1)};
        route_cases = {route_cases, route_case(MODE_NEGATIVE_FIRST, 15, 15, 0, 0, 0, 1, 0,
                                               DIR_WEST, 1)};
        // odd-even: one hop short of an odd column, source column, westward turns
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 2, 5, 0, 3, 1, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 1, 5, 0, 2, 9, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 2, 5, 2, 9, 1, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 6, 3, 0, 1, 9, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 7, 3, 0, 1, 9, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_ODD_EVEN, 4, 4, 0, 4, 0, 0, 0, '0, 0)};
        route_cases = {route_cases, route_case(MODE_FULLY_ADAPTIVE, 15, 0, 0, 0, 15, 1, 0,
                                               DIR_SOUTH | DIR_WEST, 2)};
        route_cases = {route_cases, route_case(MODE_FULLY_ADAPTIVE, 0, 15, 0, 15, 0, 1, 0,
                                               DIR_NORTH | DIR_EAST, 2)};
        route_cases = {route_cases, route_case(MODE_FULLY_ADAPTIVE, 5, 5, 5, 5, 5, 1, 1,
                                               '0, 0)};
        route_cases = {route_cases, route_case(MODE_SPARE_6, 3, 3, 0, 9, 9, 1, 0,
                                               DIR_EAST, 1)};
        route_cases = {route_cases, route_case(MODE_SPARE_7, 3, 3, 0, 3, 0, 1, 0,
                                               DIR_NORTH, 1)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table, switching mode only when a row asks for it
        foreach (route_cases[k])
        begin
            if (route_cases[k].mode != routing_mode_q)
                write_routing_mode(route_cases[k].mode);
            send_route(route_cases[k].req, route_cases[k].typed ? route_cases[k].rsp
                       : route_candidates(routing_mode_q, route_cases[k].req));
        end

        // Random headers, one mode per phase
        for (int p = 0; p < PHASES; p++)
        begin
            write_routing_mode(phase_modes[p]);
            if (p == 2)
                rx_hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                no_idle     = (p == 2 || p % 3 == 1) && i < 30;
                req.cur_x   = coord_t'($urandom_range(0, 15));
                req.cur_y   = coord_t'($urandom_range(0, 15));
                req.src_x   = coord_t'($urandom_range(0, 15));
                req.dst_x   = coord_t'($urandom_range(0, 15));
                req.dst_y   = coord_t'($urandom_range(0, 15));
                kind        = $urandom_range(0, 9);
                case (kind)
                    0:
                    begin
                        req.dst_x = req.cur_x;
                        req.dst_y = req.cur_y;
                    end
                    1: req.dst_x = req.cur_x;
                    2: req.dst_y = req.cur_y;
                    3:
                    begin
                        req.cur_x = $urandom_range(0, 1) ? 4'hF : 4'h0;
                        req.cur_y = $urandom_range(0, 1) ? 4'hF : 4'h0;
                        req.src_x = $urandom_range(0, 1) ? 4'hF : 4'h0;
                        req.dst_x = $urandom_range(0, 1) ? 4'hF : 4'h0;
                        req.dst_y = $urandom_range(0, 1) ? 4'hF : 4'h0;
                    end
                    4: req.src_x = req.cur_x;
                    5: req.dst_x = (req.cur_x == 4'hF) ? 4'hF : req.cur_x + 4'd1;
                    default:
                        ;
                endcase
                send_route(req, route_candidates(routing_mode_q, req));
                // pause the sender mid-phase until the block is empty
                if (i == ITEMS_PER_PHASE / 2)
                    drain_routes();
            end
        end
        no_idle = 1'b0;

        drain_routes();
        repeat (8) @(posedge clk);
        if (route_errors == 0 && route_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
